// ----- hdl/fmpa_pkg.sv -----
package fmpa_pkg;

    // Field and register widths.
    localparam int PHASE_W   = 32;
    localparam int SAMPLE_W  = 16;
    localparam int OUT_W     = 16;
    localparam int GAIN_W    = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 1;
    localparam int PROD_W    = GAIN_W + SAMPLE_W;

    // CORDIC datapath.
    localparam int CORDIC_STAGES = 16;
    localparam int ITER_W        = $clog2(CORDIC_STAGES);
    localparam int XY_W          = 34;
    localparam int Z_W           = 33;
    localparam logic signed [XY_W-1:0] CORDIC_X0 = XY_W'(652032874);

    // Output scaling: Q2.30 value times full scale, rounded, shifted down by 30.
    localparam int SCALE_SHIFT = 30;
    localparam int SCALE_W     = XY_W + OUT_W;
    localparam int OUT_FULL    = 2 ** (OUT_W - 1) - 1;

    // Queue between the front and the back.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FREQ_GAIN   = 1'b0,
        REG_START_PHASE = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROTATE,
        ST_SCALE,
        ST_OUTPUT
    } back_state_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               last;
    } qent_t;

    // Arctangent of 2^-i in 2^-32 turns.
    function automatic logic signed [Z_W-1:0] atan_lut(input logic [ITER_W-1:0] idx);
        logic signed [Z_W-1:0] val;
        begin
            case (idx)
                4'd0:    val = Z_W'(536870912);
                4'd1:    val = Z_W'(316933406);
                4'd2:    val = Z_W'(167458907);
                4'd3:    val = Z_W'(85004756);
                4'd4:    val = Z_W'(42667331);
                4'd5:    val = Z_W'(21354465);
                4'd6:    val = Z_W'(10679838);
                4'd7:    val = Z_W'(5340245);
                4'd8:    val = Z_W'(2670163);
                4'd9:    val = Z_W'(1335087);
                4'd10:   val = Z_W'(667544);
                4'd11:   val = Z_W'(333772);
                4'd12:   val = Z_W'(166886);
                4'd13:   val = Z_W'(83443);
                4'd14:   val = Z_W'(41722);
                4'd15:   val = Z_W'(20861);
                default: val = '0;
            endcase
            return val;
        end
    endfunction

endpackage

// ----- hdl/fmpa_front.sv -----
module fmpa_front
    import fmpa_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]           cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       last_in,
    output logic                       push_valid,
    input  logic                       push_ready,
    output qent_t                      push_data
);

    logic signed [GAIN_W-1:0] gain_reg;
    logic [PHASE_W-1:0]       acc_reg;
    logic                     prod_valid_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_last_reg;

    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] step_full;
    logic [PHASE_W-1:0]       acc_next;
    logic                     in_fire;
    logic                     push_fire;

    assign in_ready   = !prod_valid_reg || push_ready;
    assign in_fire    = in_valid && in_ready;
    assign push_valid = prod_valid_reg;
    assign push_fire  = prod_valid_reg && push_ready;

    assign prod_next = gain_reg * sample;
    // Arithmetic shift gives the floor of the scaled product.
    assign step_full = prod_reg >>> (SAMPLE_W - 1);
    assign acc_next  = acc_reg + step_full[PHASE_W-1:0];

    assign push_data.phase = acc_next;
    assign push_data.last  = prod_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg       <= '0;
            acc_reg        <= '0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_FREQ_GAIN:   gain_reg <= cfg_data[GAIN_W-1:0];
                    REG_START_PHASE: acc_reg  <= cfg_data[PHASE_W-1:0];
                    default:         ;
                endcase
            end
            else if (push_fire)
            begin
                acc_reg <= acc_next;
            end

            if (in_fire)
                prod_valid_reg <= 1'b1;
            else if (push_fire)
                prod_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            prod_reg      <= prod_next;
            prod_last_reg <= last_in;
        end
    end

    // The accumulator moves only when a phase leaves for the queue or on a load.
    a_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!push_fire && !(cfg_write && cfg_index == REG_START_PHASE))
        |=> acc_reg == $past(acc_reg))
        else $error("phase accumulator changed without a push or a load");

endmodule

// ----- hdl/fmpa_queue.sv -----
module fmpa_queue
    import fmpa_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  qent_t push_data,
    output logic  pop_valid,
    input  logic  pop_ready,
    output qent_t pop_data
);

    qent_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              push;
    logic              pop;

    assign push_ready = (count_reg != QCNT_W'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= QPTR_W'(wr_ptr_reg + 1'b1);
            if (pop)
                rd_ptr_reg <= QPTR_W'(rd_ptr_reg + 1'b1);
            if (push && !pop)
                count_reg <= QCNT_W'(count_reg + 1'b1);
            else if (pop && !push)
                count_reg <= QCNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count beyond its depth");

    a_count_inc: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == QCNT_W'($past(count_reg) + 1'b1))
        else $error("queue count did not follow a push");

endmodule

// ----- hdl/fmpa_back.sv -----
module fmpa_back
    import fmpa_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    output logic                    q_ready,
    input  qent_t                   q_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [OUT_W-1:0] i_out,
    output logic signed [OUT_W-1:0] q_out,
    output logic                    last_out
);

    localparam logic signed [OUT_W-1:0]   FULL_S   = OUT_W'(OUT_FULL);
    localparam logic signed [SCALE_W-1:0] FULL_EXT = SCALE_W'(OUT_FULL);
    localparam logic signed [SCALE_W-1:0] RND      = SCALE_W'(2 ** (SCALE_SHIFT - 1));

    back_state_t               state_reg, state_next;
    logic signed [XY_W-1:0]    x_reg, x_next;
    logic signed [XY_W-1:0]    y_reg, y_next;
    logic signed [Z_W-1:0]     z_reg, z_next;
    logic [ITER_W-1:0]         iter_reg, iter_next;
    logic [1:0]                quad_reg, quad_next;
    logic                      last_reg, last_next;
    logic signed [SCALE_W-1:0] mi_reg, mi_next;
    logic signed [SCALE_W-1:0] mq_reg, mq_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [OUT_W-1:0]   i_out_reg, i_out_next;
    logic signed [OUT_W-1:0]   q_out_reg, q_out_next;
    logic                      last_out_reg, last_out_next;

    logic                      out_free;
    logic [PHASE_W-1:0]        p_rot;
    logic [1:0]                quad_in;
    logic [PHASE_W-1:0]        ru;
    logic signed [XY_W-1:0]    x_sh;
    logic signed [XY_W-1:0]    y_sh;
    logic signed [XY_W-1:0]    ci;
    logic signed [XY_W-1:0]    cq;

    function automatic logic signed [OUT_W-1:0] saturate(input logic signed [SCALE_W-1:0] m);
        logic signed [SCALE_W-1:0] r;
        logic signed [OUT_W-1:0]   res;
        begin
            r = (m + RND) >>> SCALE_SHIFT;
            if (r > FULL_EXT)
                res = FULL_S;
            else if (r < -FULL_EXT)
                res = -FULL_S;
            else
                res = r[OUT_W-1:0];
            return res;
        end
    endfunction

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign i_out     = i_out_reg;
    assign q_out     = q_out_reg;
    assign last_out  = last_out_reg;

    // Fold the phase into one quadrant; the residue lies in [-1/8, 1/8) turn.
    assign p_rot   = q_data.phase + PHASE_W'(32'h2000_0000);
    assign quad_in = p_rot[PHASE_W-1:PHASE_W-2];
    assign ru      = q_data.phase - {quad_in, {(PHASE_W - 2){1'b0}}};

    assign x_sh = x_reg >>> iter_reg;
    assign y_sh = y_reg >>> iter_reg;

    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        iter_next      = iter_reg;
        quad_next      = quad_reg;
        last_next      = last_reg;
        mi_next        = mi_reg;
        mq_next        = mq_reg;
        out_valid_next = out_valid_reg;
        i_out_next     = i_out_reg;
        q_out_next     = q_out_reg;
        last_out_next  = last_out_reg;
        q_ready        = 1'b0;
        ci             = x_reg;
        cq             = y_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (quad_reg)
            2'd0:
            begin
                ci = x_reg;
                cq = y_reg;
            end
            2'd1:
            begin
                ci = -y_reg;
                cq = x_reg;
            end
            2'd2:
            begin
                ci = -x_reg;
                cq = -y_reg;
            end
            default:
            begin
                ci = y_reg;
                cq = -x_reg;
            end
        endcase

        case (state_reg)
            ST_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    x_next     = CORDIC_X0;
                    y_next     = '0;
                    z_next     = {ru[PHASE_W-1], ru};
                    iter_next  = '0;
                    quad_next  = quad_in;
                    last_next  = q_data.last;
                    state_next = ST_ROTATE;
                end
            end
            ST_ROTATE:
            begin
                if (!z_reg[Z_W-1])
                begin
                    x_next = x_reg - y_sh;
                    y_next = y_reg + x_sh;
                    z_next = z_reg - atan_lut(iter_reg);
                end
                else
                begin
                    x_next = x_reg + y_sh;
                    y_next = y_reg - x_sh;
                    z_next = z_reg + atan_lut(iter_reg);
                end
                iter_next = ITER_W'(iter_reg + 1'b1);
                if (iter_reg == ITER_W'(CORDIC_STAGES - 1))
                    state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                mi_next    = ci * FULL_S;
                mq_next    = cq * FULL_S;
                state_next = ST_OUTPUT;
            end
            ST_OUTPUT:
            begin
                if (out_free)
                begin
                    i_out_next     = saturate(mi_reg);
                    q_out_next     = saturate(mq_reg);
                    last_out_next  = last_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            iter_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            iter_reg      <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        z_reg        <= z_next;
        quad_reg     <= quad_next;
        last_reg     <= last_next;
        mi_reg       <= mi_next;
        mq_reg       <= mq_next;
        i_out_reg    <= i_out_next;
        q_out_reg    <= q_out_next;
        last_out_reg <= last_out_next;
    end

    a_start_rotate: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && q_valid) |=> (state_reg == ST_ROTATE && iter_reg == '0))
        else $error("rotation did not start at the first stage");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUTPUT && out_free) |=> out_valid_reg)
        else $error("finished result was not loaded into the output register");

endmodule

// ----- hdl/fm_phase_accumulator_modulator.sv -----
// FM modulator built around a phase accumulator and a CORDIC oscillator. Each input item
// carries a signed Q1.15 sample; it is multiplied by the signed freq_gain register, the
// product is floored to a phase step in 2^-32 turns and added to a wrapping 32-bit phase
// accumulator. The item's result is the cosine (i_out) and sine (q_out) of the new phase
// in Q1.15, saturated to +/-32767, with last_in passed through as last_out. Writing
// start_phase (index 1) loads the accumulator directly; freq_gain is index 0, and
// configuration is meant to be written while no item is in flight. The front end takes
// an item every cycle into a multiply stage, unless that stage holds a product the queue
// cannot take, and pushes the updated phase into a two-entry queue, so up to three items
// can wait ahead of the oscillator while it is busy. The oscillator runs one shared CORDIC
// stage sixteen times per item, then scales and saturates, and it takes no new phase from
// the queue until the result of the last one has been loaded into its output register.
module fm_phase_accumulator_modulator
    import fmpa_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]           cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       last_in,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [OUT_W-1:0]    i_out,
    output logic signed [OUT_W-1:0]    q_out,
    output logic                       last_out
);

    // Phases travel from the front end to the oscillator through the queue.
    logic  push_valid;
    logic  push_ready;
    qent_t push_data;
    logic  pop_valid;
    logic  pop_ready;
    qent_t pop_data;

    fmpa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample     (sample),
        .last_in    (last_in),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    fmpa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    fmpa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (pop_valid),
        .q_ready   (pop_ready),
        .q_data    (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .i_out     (i_out),
        .q_out     (q_out),
        .last_out  (last_out)
    );

endmodule

// ----- tb/sv/fm_iq_monitor.sv -----
`timescale 1ns / 1ps

// Watches the configuration port and both item channels of the FM modulator.
// It keeps its own copy of the gain and phase accumulator and computes the
// expected I/Q pair for every accepted sample.
module fm_iq_monitor
    import fmpa_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]           cfg_data,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       last_in,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic signed [OUT_W-1:0]    i_out,
    input  logic signed [OUT_W-1:0]    q_out,
    input  logic                       last_out,
    output int                         errors,
    output int                         outstanding,
    output int                         checked
);

    typedef struct {
        logic signed [OUT_W-1:0] i;
        logic signed [OUT_W-1:0] q;
        logic                    last;
    } iq_result_t;

    // CORDIC start vector, 1/K in Q2.30.
    localparam longint START_X = 652032874;

    // Rotation angles atan(2^-k) in 2^-32 turns.
    longint atan_turn [16] = '{
        536870912, 316933406, 167458907, 85004756,
        42667331,  21354465,  10679838,  5340245,
        2670163,   1335087,   667544,    333772,
        166886,    83443,     41722,     20861
    };

    logic signed [GAIN_W-1:0]  gain_reg;
    logic        [PHASE_W-1:0] phase_now;
    iq_result_t                expected_iq [$];

    function automatic logic signed [OUT_W-1:0] to_q15(input longint v);
        longint r;
        r = (v * longint'(OUT_FULL) + (longint'(1) <<< 29)) >>> 30;
        if (r > OUT_FULL)
            r = OUT_FULL;
        else if (r < -OUT_FULL)
            r = -OUT_FULL;
        return OUT_W'(r);
    endfunction

    function automatic iq_result_t predict_iq(input logic [PHASE_W-1:0] ph, input logic lst);
        logic [31:0] shifted;
        logic [1:0]  quadrant;
        logic [31:0] residual;
        longint      angle;
        longint      x;
        longint      y;
        longint      nx;
        longint      ny;
        longint      cos_v;
        longint      sin_v;
        iq_result_t  r;
        // Fold the phase into a residual of +/- 1/8 turn around the nearest axis.
        shifted  = ph + 32'h2000_0000;
        quadrant = shifted[31:30];
        residual = ph - {quadrant, 30'd0};
        angle    = longint'($signed(residual));
        x = START_X;
        y = 0;
        for (int k = 0; k < 16; k++)
        begin
            if (angle >= 0)
            begin
                nx = x - (y >>> k);
                ny = y + (x >>> k);
                angle = angle - atan_turn[k];
            end
            else
            begin
                nx = x + (y >>> k);
                ny = y - (x >>> k);
                angle = angle + atan_turn[k];
            end
            x = nx;
            y = ny;
        end
        case (quadrant)
            2'd0:    begin cos_v = x;  sin_v = y;  end
            2'd1:    begin cos_v = -y; sin_v = x;  end
            2'd2:    begin cos_v = -x; sin_v = -y; end
            default: begin cos_v = y;  sin_v = -x; end
        endcase
        r.i    = to_q15(cos_v);
        r.q    = to_q15(sin_v);
        r.last = lst;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (errors < 20)
            $display("mismatch at %0t ns: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic signed [OUT_W-1:0] got,
                               input logic signed [OUT_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    always @(posedge clk)
    begin : watch
        longint     phase_step;
        iq_result_t want;
        if (!rst_n)
        begin
            gain_reg  = '0;
            phase_now = '0;
            expected_iq.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_FREQ_GAIN:   gain_reg  = cfg_data;
                    REG_START_PHASE: phase_now = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                phase_step = (longint'(gain_reg) * longint'(sample)) >>> (SAMPLE_W - 1);
                phase_now  = phase_now + PHASE_W'(phase_step);
                expected_iq.push_back(predict_iq(phase_now, last_in));
            end
            if (out_valid && out_ready)
            begin
                if (expected_iq.size() == 0)
                    report_mismatch($sformatf("result i=%0d q=%0d with no sample pending",
                                              i_out, q_out));
                else
                begin
                    want = expected_iq.pop_front();
                    check_field("i_out", i_out, want.i);
                    check_field("q_out", q_out, want.q);
                    check_field("last_out", OUT_W'(last_out), OUT_W'(want.last));
                    checked++;
                end
            end
        end
        outstanding = expected_iq.size();
    end

endmodule

// ----- tb/sv/tb_fm_phase_accumulator_modulator.sv -----
`timescale 1ns / 1ps

// Stimulus and verdict for the FM modulator. The monitor beside the block does
// all prediction and comparison; this module only drives the ports.
module tb_fm_phase_accumulator_modulator
    import fmpa_pkg::*;
();

    // Hard stop for a hung block.
    localparam int CYCLE_LIMIT   = 400000;
    // After the last result, this many quiet cycles leave the block
    // certainly idle.
    localparam int SETTLE_CYCLES = 30;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 150;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_write;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_W-1:0]           cfg_data;
    logic                       in_valid;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_in;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [OUT_W-1:0]    i_out;
    logic signed [OUT_W-1:0]    q_out;
    logic                       last_out;

    int mismatches;
    int outstanding;
    int results_checked;
    int items_sent;
    int reg_writes;
    int cycle_count;
    int sender_gap_pct;
    int receiver_stall_pct;

    // Phases on and next to the quadrant boundaries, including a half turn,
    // where the cosine would reach -1.0 if the output were not saturated.
    logic [PHASE_W-1:0] quadrant_edges [8] = '{
        32'h0000_0000, 32'h1FFF_FFFF, 32'h2000_0000, 32'h4000_0000,
        32'h6000_0000, 32'h8000_0000, 32'hC000_0000, 32'hFFFF_FFFF
    };

    logic signed [SAMPLE_W-1:0] extreme_samples [5] = '{
        16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0001, 16'shFFFF
    };

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    fm_phase_accumulator_modulator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample    (sample),
        .last_in   (last_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .i_out     (i_out),
        .q_out     (q_out),
        .last_out  (last_out)
    );

    fm_iq_monitor u_iq_monitor (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .sample      (sample),
        .last_in     (last_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .i_out       (i_out),
        .q_out       (q_out),
        .last_out    (last_out),
        .errors      (mismatches),
        .outstanding (outstanding),
        .checked     (results_checked)
    );

    // The receiver stalls on a random share of cycles. The choice is made once
    // per falling edge, so out_ready never gets two updates in one step.
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);

    // Watchdog: a block that stops answering must still end the run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_fm_phase_accumulator_modulator failed");
            $finish;
        end
    end

    // Offers one item and returns at the falling edge after it was accepted,
    // with valid still high. The caller's next assignment to in_valid in that
    // step is then the only one.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value, input logic burst_end);
        while ($urandom_range(99) < sender_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        sample   <= value;
        last_in  <= burst_end;
        // in_ready is read right at the rising edge, before the block updates it.
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // Drops valid, waits for every predicted result, then lets the pipeline
    // settle so that a register write cannot overtake an item in flight.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // One-cycle write strobe, lowered again before the task returns so that two writes in a
    // row never raise and lower the strobe in the same step.
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        reg_writes++;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        logic signed [SAMPLE_W-1:0] value;
        logic [CFG_W-1:0]           gain_val;
        logic [CFG_W-1:0]           phase_val;
        int                         burst_left;

        // Every input is known from time zero, with reset held low at the start.
        rst_n              = 1'b0;
        cfg_write          = 1'b0;
        cfg_index          = REG_FREQ_GAIN;
        cfg_data           = '0;
        in_valid           = 1'b0;
        sample             = '0;
        last_in            = 1'b0;
        sender_gap_pct     = 35;
        receiver_stall_pct = 47;
        burst_left         = 0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, first with zero gain: the start phase alone sets the
        // output angle, so each quadrant boundary and the half turn are hit
        // exactly while the sample field sweeps its extremes.
        write_reg(REG_FREQ_GAIN, '0);
        for (int k = 0; k < 8; k++)
        begin
            write_reg(REG_START_PHASE, quadrant_edges[k]);
            send_sample(extreme_samples[k % 5], k[0]);
            wait_idle();
        end

        // Then the most positive and most negative gain, where full-scale
        // samples give the largest steps and the accumulator wraps.
        for (int g = 0; g < 2; g++)
        begin
            write_reg(REG_FREQ_GAIN, (g == 0) ? 32'h7FFF_FFFF : 32'h8000_0000);
            write_reg(REG_START_PHASE, 32'h4000_0000);
            for (int k = 0; k < 5; k++)
                send_sample(extreme_samples[k], k == 4);
            wait_idle();
        end

        // Random part. Each phase gets its own gain and start phase. Sender
        // gaps and receiver stalls come in at 35/47, then 47/35, then neither.
        for (int phase_no = 0; phase_no < RANDOM_PHASES; phase_no++)
        begin
            case (phase_no / 2)
                0:       begin sender_gap_pct = 35; receiver_stall_pct = 47; end
                1:       begin sender_gap_pct = 47; receiver_stall_pct = 35; end
                default: begin sender_gap_pct = 0;  receiver_stall_pct = 0;  end
            endcase
            case (phase_no)
                0:       begin gain_val = 32'h7FFF_FFFF; phase_val = 32'hFFFF_FFFF; end
                1:       begin gain_val = $urandom;      phase_val = $urandom;      end
                2:       begin gain_val = 32'h8000_0000; phase_val = 32'h0000_0000; end
                3:       begin gain_val = $urandom_range(2**21) - 2**20; phase_val = $urandom; end
                4:       begin gain_val = $urandom;      phase_val = 32'h8000_0000; end
                default: begin gain_val = $urandom_range(2**12) - 2**11; phase_val = $urandom; end
            endcase
            write_reg(REG_FREQ_GAIN, gain_val);
            write_reg(REG_START_PHASE, phase_val);

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Bursts of 1 to 16 samples, last flag on the final one.
                if (burst_left == 0)
                    burst_left = $urandom_range(16, 1);
                burst_left--;
                // Mostly full-range samples, some near zero, some at full scale.
                case ($urandom_range(7))
                    0:       value = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
                    1, 2:    value = SAMPLE_W'($urandom_range(127)) - 16'sd64;
                    default: value = SAMPLE_W'($urandom);
                endcase
                send_sample(value, burst_left == 0);
            end
            wait_idle();
        end

        $display("Run covered %0d samples, %0d register writes, %0d I/Q results compared,",
                 items_sent, reg_writes, results_checked);
        $display("with quadrant edges, gain extremes and varied sender and receiver pauses.");
        if (mismatches == 0)
            $display("tb_fm_phase_accumulator_modulator passed");
        else
            $display("tb_fm_phase_accumulator_modulator failed");
        $finish;
    end

endmodule
